### rtl/tspc_pkg.sv
package tspc_pkg;

  localparam int TEMPO_W   = 18;
  localparam int SYNC_W    = 13;
  localparam int BEATS_W   = 40;
  localparam int SR_W      = 19;
  localparam int SR60_W    = 25;
  localparam int DPROD_W   = 38;
  localparam int MIDT_W    = 40;
  localparam int COUNT_W   = 32;
  localparam int OUT_W     = 32;
  localparam int PADDR_W   = 3;

  localparam logic [SR_W-1:0]   SR_RESET   = 19'd48000;
  localparam logic [SR60_W-1:0] SR60_RESET = 25'd2880000;

  // register index carried on paddr[2]
  localparam logic CFG_IDX_SR = 1'b0;

  localparam logic [1:0] MODE_RESET   = 2'd0;
  localparam logic [1:0] MODE_PREPARE = 2'd1;
  localparam logic [1:0] MODE_TICK    = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  localparam logic [1:0] CODE_STEADY = 2'd0;
  localparam logic [1:0] CODE_DECEL  = 2'd1;
  localparam logic [1:0] CODE_ACCEL  = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [TEMPO_W-1:0] tempo;
    logic [SYNC_W-1:0]  sync_beats;
    logic [BEATS_W-1:0] beats_elapsed;
  } item_t;

  typedef struct packed {
    logic [OUT_W-1:0] phase;
    logic [1:0]       state_code;
  } result_t;

  typedef enum logic {OP_DIV, OP_MUL} arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

endpackage

### rtl/tspc_arith.sv
module tspc_arith #(
  parameter int NUM_W  = 72,
  parameter int DEN_W  = 40,
  parameter int PROD_W = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tspc_pkg::arith_req_t req,
  input  logic [NUM_W-1:0]     a,
  input  logic [DEN_W-1:0]     b,
  output logic                 done,
  output logic [NUM_W-1:0]     quot,
  output logic [PROD_W-1:0]    prod
);
  import tspc_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic              busy;
  arith_op_t         op;
  logic [CNT_W-1:0]  cnt;
  logic [NUM_W-1:0]  nq;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dvs;
  logic [PROD_W-1:0] mcand;
  logic [PROD_W-1:0] acc;
  logic [DEN_W:0]    r2;
  logic [DEN_W:0]    diff;
  logic              ge;

  // one restoring step: bring in the next numerator bit, subtract if it fits
  always_comb begin
    r2   = {rem, nq[NUM_W-1]};
    diff = r2 - {1'b0, dvs};
    ge   = (r2 >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op   <= OP_DIV;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        cnt  <= (req.op == OP_DIV) ? CNT_W'(NUM_W) : CNT_W'(DEN_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      nq    <= a;
      rem   <= '0;
      dvs   <= b;
      mcand <= PROD_W'(a);
      acc   <= '0;
    end else if (busy) begin
      unique case (op)
        OP_DIV: begin
          rem <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
          nq  <= {nq[NUM_W-2:0], ge};
        end
        OP_MUL: begin
          if (dvs[0]) begin
            acc <= acc + mcand;
          end
          mcand <= mcand << 1;
          dvs   <= dvs >> 1;
        end
      endcase
    end
  end

  assign quot = nq;
  assign prod = acc;

endmodule

### rtl/tempo_sync_phase_chaser.sv
// Tempo-synced LFO phase with a chasing phase. Send a reset beat (mode 0) to
// load the per-sample increment tempo / (60 * sample_rate * sync_beats), a
// prepare beat (mode 1) at each audio block start to realign the true phase
// to the song position, and one tick beat (mode 2) per sample; each tick
// returns one result beat with the Q0.32 phase and the state before the tick
// (steady, decelerating, accelerating). When tempo or sync length changes at
// a prepare, the output brakes toward a midpoint velocity and then speeds up
// to the new increment so that it lands on the true phase again. The
// divisions and the transition multiplications run on one shared
// shift-subtract divider / shift-add multiplier, one bit per clock. A
// steady tick uses no division; a tick during a transition takes one
// division and one multiplication; a reset beat one division; a prepare
// two divisions, or up to six divisions and one multiplication when
// tempo or sync changed. item_ready is high only while the sequencer is
// idle; a finished result sits in the output register and does not block
// the next beat until another result needs that register. The sample_rate
// register is written through the APB port; the user must write it only
// while idle, the block itself does not enforce this.
module tempo_sync_phase_chaser #(
  parameter int PHASE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tspc_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  tspc_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output tspc_pkg::result_t              result
);
  import tspc_pkg::*;

  localparam int NUM_W  = PHASE_BITS + 40;
  localparam int DEN_W  = (PHASE_BITS > 40) ? PHASE_BITS : 40;
  localparam int PROD_W = 2 * PHASE_BITS;
  localparam int VEL_W  = PHASE_BITS + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_INC_NEW, S_INC_NEW_W, S_BP_TRUE_W, S_INC_OLD_W, S_BP_CHASE_W,
    S_MT, S_MT_W, S_TRAVEL, S_TRAVEL_W, S_MV_W, S_EMIT, S_R_W, S_BL_W
  } seq_t;

  seq_t seq;

  // configuration
  logic [SR_W-1:0]   sample_rate;
  logic [SR60_W-1:0] sr60;
  logic              cfg_wr;

  // block state
  logic [1:0]            mode_state;
  logic [PHASE_BITS-1:0] true_increment;
  logic [PHASE_BITS-1:0] true_phase;
  logic [PHASE_BITS-1:0] old_increment;
  logic [PHASE_BITS-1:0] chase_phase;
  logic [TEMPO_W-1:0]    previous_tempo;
  logic [SYNC_W-1:0]     previous_sync;
  logic [MIDT_W-1:0]     midpoint_time;
  logic [VEL_W-1:0]      midpoint_velocity;
  logic [COUNT_W-1:0]    transition_count;
  item_t                 cur;

  // shared unit hookup
  arith_req_t         req;
  logic [NUM_W-1:0]   arg_a;
  logic [DEN_W-1:0]   arg_b;
  logic               a_zero;
  logic               d_zero;
  logic               ar_done;
  logic [NUM_W-1:0]   quot;
  logic [PROD_W-1:0]  prod;

  // launch selection
  logic               fire;
  arith_op_t          l_op;
  logic [NUM_W-1:0]   l_a;
  logic [DEN_W-1:0]   l_b;

  logic [SYNC_W-1:0]     den_sync;
  logic [DPROD_W-1:0]    den_prod;
  logic                  changed;
  logic                  slot_free;
  logic [PHASE_BITS-1:0] q_sat_p;
  logic [MIDT_W-1:0]     q_sat_t;
  logic [VEL_W-1:0]      q_sat_v;
  logic [PHASE_BITS-1:0] q_frac;
  logic [PHASE_BITS:0]   inc_sum;
  logic [PHASE_BITS-1:0] travel;
  logic [PHASE_BITS-1:0] err;
  logic [VEL_W-1:0]      bl_from;
  logic [VEL_W-1:0]      bl_to;
  logic                  bl_up;
  logic [VEL_W-1:0]      bl_mag;
  logic [PHASE_BITS-1:0] bl_x;
  logic [PHASE_BITS-1:0] bl_step;
  logic [PHASE_BITS-1:0] chase_next;
  logic [COUNT_W:0]      count_next;
  logic                  half_done;
  logic [OUT_W-1:0]      out_phase;

  tspc_arith #(
    .NUM_W  (NUM_W),
    .DEN_W  (DEN_W),
    .PROD_W (PROD_W)
  ) u_arith (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .a    (arg_a),
    .b    (arg_b),
    .done (ar_done),
    .quot (quot),
    .prod (prod)
  );

  // APB: one register, writes land on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_SR);
  assign prdata = (paddr[2] == CFG_IDX_SR) ? {{(32 - SR_W){1'b0}}, sample_rate} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= SR_RESET;
      sr60        <= SR60_RESET;
    end else if (cfg_wr) begin
      sample_rate <= pwdata[SR_W-1:0];
      // 60 * rate as 64x - 4x, kept so the divisor needs a single multiply
      sr60        <= (SR60_W'(pwdata[SR_W-1:0]) << 6) - (SR60_W'(pwdata[SR_W-1:0]) << 2);
    end
  end

  assign item_ready = (seq == S_IDLE);
  assign slot_free  = !result_valid || result_ready;
  assign changed    = (previous_tempo != cur.tempo) || (previous_sync != cur.sync_beats);

  // divisor 60 * rate * sync for either the new or the previous sync length
  assign den_sync = (seq == S_BP_TRUE_W) ? previous_sync : cur.sync_beats;
  assign den_prod = DPROD_W'(sr60) * DPROD_W'(den_sync);

  // quotient clamps: zero numerator wins, zero divisor or overflow saturates
  always_comb begin
    if (a_zero) begin
      q_sat_p = '0;
      q_sat_t = '0;
      q_sat_v = '0;
    end else begin
      q_sat_p = (d_zero || (|quot[NUM_W-1:PHASE_BITS])) ? '1 : quot[PHASE_BITS-1:0];
      q_sat_t = (d_zero || (|quot[NUM_W-1:MIDT_W]))     ? '1 : quot[MIDT_W-1:0];
      q_sat_v = (d_zero || (|quot[NUM_W-1:VEL_W]))      ? '1 : quot[VEL_W-1:0];
    end
    // fraction of beats over sync: low bits of the full quotient
    q_frac = d_zero ? '0 : quot[PHASE_BITS-1:0];
  end

  // midpoint error: distance still to cover minus travel of the average speed
  assign inc_sum = {1'b0, true_increment} + {1'b0, old_increment};
  assign travel  = prod[PHASE_BITS+8:9];
  assign err     = true_phase - chase_phase - travel;

  // velocity blend endpoints for the current half of the transition
  always_comb begin
    if (mode_state == CODE_DECEL) begin
      bl_from = VEL_W'(old_increment);
      bl_to   = midpoint_velocity;
    end else begin
      bl_from = midpoint_velocity;
      bl_to   = VEL_W'(true_increment);
    end
    bl_up   = (bl_to >= bl_from);
    bl_mag  = bl_up ? (bl_to - bl_from) : (bl_from - bl_to);
    bl_x    = prod[PROD_W-1:PHASE_BITS];
    bl_step = bl_up ? (bl_from[PHASE_BITS-1:0] + bl_x) : (bl_from[PHASE_BITS-1:0] - bl_x);
  end

  assign chase_next = chase_phase + bl_step;
  assign count_next = {1'b0, transition_count} + {{COUNT_W{1'b0}}, 1'b1};
  assign half_done  = ({count_next, 8'h00} >= {1'b0, midpoint_time});

  // Q0.P phase to Q0.32, truncating when P exceeds 32
  always_comb begin
    if (mode_state == CODE_STEADY) begin
      out_phase = OUT_W'({true_phase, {OUT_W{1'b0}}} >> PHASE_BITS);
    end else begin
      out_phase = OUT_W'({chase_phase, {OUT_W{1'b0}}} >> PHASE_BITS);
    end
  end

  // which operation each step hands to the shared unit, and when
  always_comb begin
    fire = 1'b0;
    l_op = OP_DIV;
    l_a  = '0;
    l_b  = '0;
    unique case (seq)
      S_INC_NEW: begin
        fire = 1'b1;
        l_a  = NUM_W'(cur.tempo) << PHASE_BITS;
        l_b  = DEN_W'(den_prod);
      end
      S_INC_NEW_W: begin
        fire = ar_done && (cur.mode == MODE_PREPARE);
        l_a  = NUM_W'(cur.beats_elapsed) << PHASE_BITS;
        l_b  = DEN_W'({cur.sync_beats, 8'h00});
      end
      S_BP_TRUE_W: begin
        fire = ar_done && changed;
        l_a  = NUM_W'(previous_tempo) << PHASE_BITS;
        l_b  = DEN_W'(den_prod);
      end
      S_INC_OLD_W: begin
        fire = ar_done && (mode_state == CODE_STEADY);
        l_a  = NUM_W'(cur.beats_elapsed) << PHASE_BITS;
        l_b  = DEN_W'({previous_sync, 8'h00});
      end
      S_MT: begin
        fire = (true_increment != '0);
        l_a  = NUM_W'(1) << (PHASE_BITS + 7);
        l_b  = DEN_W'(true_increment);
      end
      S_TRAVEL: begin
        fire = 1'b1;
        l_op = OP_MUL;
        l_a  = NUM_W'(inc_sum);
        l_b  = DEN_W'(midpoint_time);
      end
      S_TRAVEL_W: begin
        fire = ar_done;
        l_a  = NUM_W'(err) << 8;
        l_b  = DEN_W'(midpoint_time);
      end
      S_EMIT: begin
        fire = slot_free && (mode_state != CODE_STEADY);
        l_a  = NUM_W'(transition_count) << (PHASE_BITS + 8);
        l_b  = DEN_W'(midpoint_time);
      end
      S_R_W: begin
        fire = ar_done;
        l_op = OP_MUL;
        l_a  = NUM_W'(bl_mag);
        l_b  = DEN_W'(q_sat_p);
      end
      default: begin
        fire = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req <= '{start: 1'b0, op: OP_DIV};
    end else begin
      req <= '{start: fire, op: l_op};
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      arg_a  <= l_a;
      arg_b  <= l_b;
      a_zero <= (l_a == '0);
      d_zero <= (l_b == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq               <= S_IDLE;
      mode_state        <= CODE_STEADY;
      true_increment    <= '0;
      true_phase        <= '0;
      old_increment     <= '0;
      chase_phase       <= '0;
      previous_tempo    <= '0;
      previous_sync     <= '0;
      midpoint_time     <= '0;
      midpoint_velocity <= '0;
      transition_count  <= '0;
      result_valid      <= 1'b0;
    end else begin
      // load a new result when one is shown, else drop the taken one
      if (seq == S_EMIT && slot_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (seq)
        S_IDLE: begin
          if (item_valid) begin
            cur <= item;
            unique case (item.mode)
              MODE_RESET, MODE_PREPARE: seq <= S_INC_NEW;
              MODE_TICK:                seq <= S_EMIT;
              MODE_NONE:                seq <= S_IDLE;
            endcase
          end
        end
        S_INC_NEW: begin
          seq <= S_INC_NEW_W;
        end
        S_INC_NEW_W: begin
          if (ar_done) begin
            true_increment <= q_sat_p;
            if (cur.mode == MODE_RESET) begin
              true_phase     <= '0;
              old_increment  <= q_sat_p;
              chase_phase    <= '0;
              previous_tempo <= cur.tempo;
              previous_sync  <= cur.sync_beats;
              seq            <= S_IDLE;
            end else begin
              seq <= S_BP_TRUE_W;
            end
          end
        end
        S_BP_TRUE_W: begin
          if (ar_done) begin
            true_phase <= q_frac;
            if (changed) begin
              seq <= S_INC_OLD_W;
            end else begin
              previous_tempo <= cur.tempo;
              previous_sync  <= cur.sync_beats;
              seq            <= S_IDLE;
            end
          end
        end
        S_INC_OLD_W: begin
          if (ar_done) begin
            old_increment <= q_sat_p;
            // a running transition keeps chasing from where it is
            seq <= (mode_state == CODE_STEADY) ? S_BP_CHASE_W : S_MT;
          end
        end
        S_BP_CHASE_W: begin
          if (ar_done) begin
            chase_phase <= q_frac;
            seq         <= S_MT;
          end
        end
        S_MT: begin
          if (true_increment == '0) begin
            // zero tempo: midpoint never arrives
            midpoint_time <= '1;
            seq           <= S_TRAVEL;
          end else begin
            seq <= S_MT_W;
          end
        end
        S_MT_W: begin
          if (ar_done) begin
            midpoint_time <= q_sat_t;
            seq           <= S_TRAVEL;
          end
        end
        S_TRAVEL: begin
          seq <= S_TRAVEL_W;
        end
        S_TRAVEL_W: begin
          if (ar_done) begin
            seq <= S_MV_W;
          end
        end
        S_MV_W: begin
          if (ar_done) begin
            midpoint_velocity <= q_sat_v;
            transition_count  <= '0;
            mode_state        <= CODE_DECEL;
            previous_tempo    <= cur.tempo;
            previous_sync     <= cur.sync_beats;
            seq               <= S_IDLE;
          end
        end
        S_EMIT: begin
          // hold until the output register is free, then show the phase
          if (slot_free) begin
            result.phase      <= out_phase;
            result.state_code <= mode_state;
            if (mode_state == CODE_STEADY) begin
              true_phase <= true_phase + true_increment;
              seq        <= S_IDLE;
            end else begin
              seq <= S_R_W;
            end
          end
        end
        S_R_W: begin
          if (ar_done) begin
            seq <= S_BL_W;
          end
        end
        S_BL_W: begin
          if (ar_done) begin
            chase_phase      <= chase_next;
            transition_count <= count_next[COUNT_W-1:0];
            if (half_done) begin
              if (mode_state == CODE_DECEL) begin
                mode_state       <= CODE_ACCEL;
                transition_count <= '0;
              end else begin
                mode_state <= CODE_STEADY;
                true_phase <= chase_next;
              end
            end
            seq <= S_IDLE;
          end
        end
        default: begin
          seq <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/tspc_checker.sv
module tspc_sva (
  input logic                         clk,
  input logic                         rst,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [tspc_pkg::PADDR_W-1:0] paddr,
  input logic [31:0]                  pwdata,
  input logic [31:0]                  prdata,
  input logic                         item_valid,
  input logic                         item_ready,
  input tspc_pkg::item_t              item,
  input logic                         result_valid,
  input logic                         result_ready,
  input tspc_pkg::result_t            result
);
  import tspc_pkg::*;

  // a reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // a stalled result stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // only the three state codes ever leave the block
  a_code_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.state_code == CODE_STEADY ||
                      result.state_code == CODE_DECEL  ||
                      result.state_code == CODE_ACCEL))
    else $error("illegal state code");

  // every real beat takes the sequencer out of idle, so item_ready falls
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.mode != MODE_NONE |=> !item_ready)
    else $error("ready right after a beat");

  // sample rate reads back what was written
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[2] == CFG_IDX_SR
    |=> (paddr[2] != CFG_IDX_SR) || prdata == {13'b0, $past(pwdata[18:0])})
    else $error("sample rate readback mismatch");

endmodule

bind tempo_sync_phase_chaser tspc_sva u_tspc_sva (.*);
